// File: rtl/core/gto_pkg.sv
`timescale 1ns / 1ps

package gto_pkg;

    // fixed field widths
    localparam int NODE_W     = 6;
    localparam int CNT_W      = 7;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    // input item kinds
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_RUN = 1'b1;

    // one stored edge
    typedef struct packed {
        logic [NODE_W-1:0] dst;
        logic [NODE_W-1:0] src;
    } edge_t;

endpackage

// File: rtl/core/graph_topological_order.sv
`timescale 1ns / 1ps

// channel   dir  handshake                fields
// s_*       in   s_tvalid / s_tready      tuser: func; tdata: src_node, dst_node
// m_*       out  m_tvalid / m_tready      tdata: node_index; tlast: last;
//                                         tuser: cycle_found, edges_dropped
// cfg_*     in   cfg_wr_en (no wait)      cfg_wr_data: node_count
//
// an add-edge item is taken whenever idle; s_tready stays high between runs
// a run item zeroes the in-degree table, then sweeps the edge store through
// its single read port once to build the in-degrees and once per popped node;
// s_tready is low until the last result of the run sits in the output
// register
// rst_n clears control state at once; the memories are not reset, each run zeroes the in-degree table itself
// a stalled m_tready holds the output register and the sequencer waits

module graph_topological_order #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: [5:0] src_node, [11:6] dst_node, [15:12] zero
    input  logic [gto_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: [0] func
    input  logic [gto_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: [5:0] node_index, [7:6] zero
    output logic [gto_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: [0] cycle_found, [1] edges_dropped
    output logic [gto_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [gto_pkg::CNT_W-1:0]      cfg_wr_data
);
    import gto_pkg::*;

    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int QAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_BLD_RD   = 4'd2;
    localparam logic [3:0] S_BLD_CHK  = 4'd3;
    localparam logic [3:0] S_BLD_INC  = 4'd4;
    localparam logic [3:0] S_SEED_RD  = 4'd5;
    localparam logic [3:0] S_SEED_CHK = 4'd6;
    localparam logic [3:0] S_POP      = 4'd7;
    localparam logic [3:0] S_POP_LD   = 4'd8;
    localparam logic [3:0] S_WALK_RD  = 4'd9;
    localparam logic [3:0] S_WALK_CHK = 4'd10;
    localparam logic [3:0] S_WALK_DEC = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;
    localparam logic [3:0] S_CYC      = 4'd13;
    localparam logic [3:0] S_EMIT_RD  = 4'd14;
    localparam logic [3:0] S_EMIT_LD  = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  node_count_reg;
    logic [ECW-1:0]    edge_total_reg, edge_total_next;
    logic              ovf_reg, ovf_next;
    logic [NCW-1:0]    head_reg, head_next;
    logic [NCW-1:0]    tail_reg, tail_next;
    logic [NCW-1:0]    idx_reg, idx_next;
    logic [ECW-1:0]    eidx_reg, eidx_next;
    logic [NODE_W-1:0] cur_reg, cur_next;

    logic              out_valid_reg, out_valid_next;
    logic [NODE_W-1:0] out_node_reg, out_node_next;
    logic              out_last_reg, out_last_next;
    logic              out_cyc_reg, out_cyc_next;
    logic              out_drop_reg, out_drop_next;

    // memories
    edge_t             edge_mem [MAX_EDGES];
    edge_t             edge_rd_reg;
    logic [ECW-1:0]    indeg_mem [MAX_NODES];
    logic [ECW-1:0]    indeg_rd_reg;
    logic [NODE_W-1:0] queue_mem [MAX_NODES];
    logic [NODE_W-1:0] queue_rd_reg;

    logic              edge_we;
    edge_t             edge_wdata;
    logic              indeg_we;
    logic [QAW-1:0]    indeg_waddr;
    logic [ECW-1:0]    indeg_wdata;
    logic [QAW-1:0]    indeg_raddr;
    logic              queue_we;
    logic [NODE_W-1:0] queue_wdata;
    logic [QAW-1:0]    queue_raddr;

    logic [CNT_W-1:0]  n_act;
    logic              in_accept;
    logic              out_free;
    logic              add_ok;
    logic              rd_edge_ok;
    logic [NODE_W-1:0] in_src;
    logic [NODE_W-1:0] in_dst;

    // active node count, clamped to 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
            n_act = CNT_W'(1);
        else if (node_count_reg > CNT_W'(MAX_NODES))
            n_act = CNT_W'(MAX_NODES);
        else
            n_act = node_count_reg;
    end

    assign in_src     = s_tdata[NODE_W-1:0];
    assign in_dst     = s_tdata[2*NODE_W-1:NODE_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign add_ok     = ({1'b0, in_src} < n_act) && ({1'b0, in_dst} < n_act);
    assign rd_edge_ok = ({1'b0, edge_rd_reg.src} < n_act) && ({1'b0, edge_rd_reg.dst} < n_act);

    // memory address selection
    assign edge_wdata  = '{dst: in_dst, src: in_src};
    assign indeg_raddr = (state_reg == S_SEED_RD) ? idx_reg[QAW-1:0]
                                                  : edge_rd_reg.dst[QAW-1:0];
    assign queue_raddr = (state_reg == S_POP) ? head_reg[QAW-1:0] : idx_reg[QAW-1:0];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        ovf_next        = ovf_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        idx_next        = idx_reg;
        eidx_next       = eidx_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_node_next   = out_node_reg;
        out_last_next   = out_last_reg;
        out_cyc_next    = out_cyc_reg;
        out_drop_next   = out_drop_reg;
        edge_we         = 1'b0;
        indeg_we        = 1'b0;
        indeg_waddr     = edge_rd_reg.dst[QAW-1:0];
        indeg_wdata     = '0;
        queue_we        = 1'b0;
        queue_wdata     = edge_rd_reg.dst;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser[0] == FUNC_RUN)
                    begin
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                    else if (add_ok)
                    begin
                        if (edge_total_reg == ECW'(MAX_EDGES))
                            ovf_next = 1'b1;
                        else
                        begin
                            edge_we         = 1'b1;
                            edge_total_next = edge_total_reg + ECW'(1);
                        end
                    end
                end
            end
            // zero the in-degree table
            S_CLR:
            begin
                indeg_we    = 1'b1;
                indeg_waddr = idx_reg[QAW-1:0];
                indeg_wdata = '0;
                idx_next    = idx_reg + NCW'(1);
                if (idx_reg == NCW'(MAX_NODES - 1))
                begin
                    eidx_next  = '0;
                    state_next = S_BLD_RD;
                end
            end
            // rebuild in-degrees from the edge store
            S_BLD_RD:
            begin
                if (eidx_reg == edge_total_reg)
                begin
                    idx_next   = '0;
                    state_next = S_SEED_RD;
                end
                else
                    state_next = S_BLD_CHK;
            end
            S_BLD_CHK:
            begin
                if (rd_edge_ok)
                    state_next = S_BLD_INC;
                else
                begin
                    eidx_next  = eidx_reg + ECW'(1);
                    state_next = S_BLD_RD;
                end
            end
            S_BLD_INC:
            begin
                indeg_we    = 1'b1;
                indeg_wdata = indeg_rd_reg + ECW'(1);
                eidx_next   = eidx_reg + ECW'(1);
                state_next  = S_BLD_RD;
            end
            // queue the zero in-degree nodes in index order
            S_SEED_RD:
            begin
                if (CNT_W'(idx_reg) == n_act)
                    state_next = S_POP;
                else
                    state_next = S_SEED_CHK;
            end
            S_SEED_CHK:
            begin
                if (indeg_rd_reg == '0)
                begin
                    queue_we    = 1'b1;
                    queue_wdata = NODE_W'(idx_reg);
                    tail_next   = tail_reg + NCW'(1);
                end
                idx_next   = idx_reg + NCW'(1);
                state_next = S_SEED_RD;
            end
            // pop the next node
            S_POP:
            begin
                if (head_reg == tail_reg)
                    state_next = S_DONE;
                else
                    state_next = S_POP_LD;
            end
            S_POP_LD:
            begin
                cur_next   = queue_rd_reg;
                head_next  = head_reg + NCW'(1);
                eidx_next  = '0;
                state_next = S_WALK_RD;
            end
            // walk the out-edges of the popped node in arrival order
            S_WALK_RD:
            begin
                if (eidx_reg == edge_total_reg)
                    state_next = S_POP;
                else
                    state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (rd_edge_ok && (edge_rd_reg.src == cur_reg))
                    state_next = S_WALK_DEC;
                else
                begin
                    eidx_next  = eidx_reg + ECW'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_DEC:
            begin
                if (indeg_rd_reg != '0)
                begin
                    indeg_we    = 1'b1;
                    indeg_wdata = indeg_rd_reg - ECW'(1);
                    if (indeg_rd_reg == ECW'(1))
                    begin
                        queue_we  = 1'b1;
                        tail_next = tail_reg + NCW'(1);
                    end
                end
                eidx_next  = eidx_reg + ECW'(1);
                state_next = S_WALK_RD;
            end
            // every node ordered or a cycle left behind
            S_DONE:
            begin
                idx_next = '0;
                if (CNT_W'(tail_reg) == n_act)
                    state_next = S_EMIT_RD;
                else
                    state_next = S_CYC;
            end
            S_CYC:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_node_next   = '0;
                    out_last_next   = 1'b1;
                    out_cyc_next    = 1'b1;
                    out_drop_next   = ovf_reg;
                    edge_total_next = '0;
                    head_next       = '0;
                    tail_next       = '0;
                    state_next      = S_IDLE;
                end
            end
            // stream the ordered queue
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = queue_rd_reg;
                    out_last_next  = (CNT_W'(idx_reg) == n_act - CNT_W'(1));
                    out_cyc_next   = 1'b0;
                    out_drop_next  = ovf_reg;
                    idx_next       = idx_reg + NCW'(1);
                    if (CNT_W'(idx_reg) == n_act - CNT_W'(1))
                    begin
                        edge_total_next = '0;
                        head_next       = '0;
                        tail_next       = '0;
                        state_next      = S_IDLE;
                    end
                    else
                        state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CNT_W'(1);
            edge_total_reg <= '0;
            ovf_reg        <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            idx_reg        <= '0;
            eidx_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            ovf_reg        <= ovf_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            idx_reg        <= idx_next;
            eidx_reg       <= eidx_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                node_count_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_node_reg <= out_node_next;
        out_last_reg <= out_last_next;
        out_cyc_reg  <= out_cyc_next;
        out_drop_reg <= out_drop_next;
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_total_reg[EAW-1:0]] <= edge_wdata;
        edge_rd_reg <= edge_mem[eidx_reg[EAW-1:0]];
    end

    // in-degree table
    always_ff @(posedge clk)
    begin
        if (indeg_we)
            indeg_mem[indeg_waddr] <= indeg_wdata;
        indeg_rd_reg <= indeg_mem[indeg_raddr];
    end

    // order queue
    always_ff @(posedge clk)
    begin
        if (queue_we)
            queue_mem[tail_reg[QAW-1:0]] <= queue_wdata;
        queue_rd_reg <= queue_mem[queue_raddr];
    end

    // output port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_node_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_drop_reg, out_cyc_reg};

    // checks
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(tail_reg) <= n_act)
        else $error("queue holds more nodes than are active");

    a_edge_total: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ECW'(MAX_EDGES))
        else $error("edge count above store depth");

    a_cycle_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_cyc_reg) |-> (out_last_reg && (out_node_reg == '0)))
        else $error("cycle item is not a single zero item");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_tvalid) && out_last_reg) |-> (state_reg == S_IDLE))
        else $error("sequencer busy after loading the final item");

endmodule

// File: sim/graph_topological_order_checker.sv
`timescale 1ns / 1ps

module graph_topological_order_checker #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: [5:0] src_node, [11:6] dst_node, [15:12] zero
    input  logic [gto_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: [0] func
    input  logic [gto_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // tdata: [5:0] node_index, [7:6] zero
    input  logic [gto_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: [0] cycle_found, [1] edges_dropped
    input  logic [gto_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                           m_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [gto_pkg::CNT_W-1:0]      cfg_wr_data,
    output int                             mismatch_count,
    output int                             nodes_outstanding
);

    typedef struct packed {
        logic [gto_pkg::NODE_W-1:0] node_index;
        logic                       last;
        logic                       cycle_found;
        logic                       edges_dropped;
    } order_entry_t;

    // shadow copy of the graph held by the block
    logic [gto_pkg::CNT_W-1:0]  node_count_q;
    logic [gto_pkg::NODE_W-1:0] edge_src [MAX_EDGES];
    logic [gto_pkg::NODE_W-1:0] edge_dst [MAX_EDGES];
    int unsigned                edge_count;
    logic                       overflow_seen;

    order_entry_t expected_order [$];

    // register value as the sort sees it
    function automatic int unsigned active_nodes(input logic [gto_pkg::CNT_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > MAX_NODES)
            return MAX_NODES;
        return value;
    endfunction

    // kahn sort over the stored edges, queues the emitted order
    task automatic predict_order();
        int unsigned                n;
        int unsigned                head;
        int unsigned                tail;
        int unsigned                in_degree [MAX_NODES];
        logic [gto_pkg::NODE_W-1:0] ready_nodes [MAX_NODES];
        logic [gto_pkg::NODE_W-1:0] cur;
        logic [gto_pkg::NODE_W-1:0] dst;
        order_entry_t               entry;
        order_entry_t               run_order [$];
        n = active_nodes(node_count_q);
        head = 0;
        tail = 0;
        foreach (in_degree[i])
            in_degree[i] = 0;
        // in-degrees from edges valid under the current count
        for (int e = 0; e < edge_count; e++)
        begin
            if (edge_src[e] < n && edge_dst[e] < n)
                in_degree[edge_dst[e]]++;
        end
        for (int i = 0; i < n; i++)
        begin
            if (in_degree[i] == 0)
            begin
                ready_nodes[tail] = 6'(i);
                tail++;
            end
        end
        // pop in queue order, release successors in arrival order
        while (head < tail)
        begin
            cur = ready_nodes[head];
            head++;
            entry = '{cur, 1'b0, 1'b0, overflow_seen};
            run_order.insert(run_order.size(), entry);
            for (int e = 0; e < edge_count; e++)
            begin
                dst = edge_dst[e];
                if (edge_src[e] == cur && dst < n && in_degree[dst] > 0)
                begin
                    in_degree[dst]--;
                    if (in_degree[dst] == 0 && tail < MAX_NODES)
                    begin
                        ready_nodes[tail] = dst;
                        tail++;
                    end
                end
            end
        end
        // unreached nodes collapse the run into one cycle result
        if (run_order.size() != n)
        begin
            run_order.delete();
            entry = '{6'd0, 1'b1, 1'b1, overflow_seen};
            run_order.insert(0, entry);
        end
        else
        begin
            run_order[run_order.size()-1].last = 1'b1;
        end
        foreach (run_order[i])
            expected_order.insert(expected_order.size(), run_order[i]);
        edge_count = 0;
    endtask

    // watch all channels and compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        order_entry_t               want;
        logic [gto_pkg::NODE_W-1:0] src;
        logic [gto_pkg::NODE_W-1:0] dst;
        int unsigned                n;
        if (!rst_n)
        begin
            node_count_q = 7'd1;
            edge_count = 0;
            overflow_seen = 1'b0;
            expected_order.delete();
            mismatch_count = 0;
            nodes_outstanding = 0;
        end
        else
        begin
            // result side
            if (m_tvalid && m_tready)
            begin
                if (expected_order.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got node %0d last %0b tuser %b",
                             $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = expected_order.pop_front();
                    if (m_tdata != {2'b00, want.node_index} || m_tlast != want.last ||
                        m_tuser[0] != want.cycle_found || m_tuser[1] != want.edges_dropped)
                    begin
                        mismatch_count++;
                        $display("%0t: result mismatch, expected node %0d last %0b cycle %0b dropped %0b, got tdata %0d last %0b cycle %0b dropped %0b",
                                 $time, want.node_index, want.last, want.cycle_found,
                                 want.edges_dropped, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                    end
                end
            end
            // register write
            if (cfg_wr_en)
                node_count_q = cfg_wr_data;
            // input side
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == gto_pkg::FUNC_RUN)
                begin
                    predict_order();
                end
                else
                begin
                    src = s_tdata[5:0];
                    dst = s_tdata[11:6];
                    n = active_nodes(node_count_q);
                    if (src < n && dst < n)
                    begin
                        if (edge_count >= MAX_EDGES)
                        begin
                            overflow_seen = 1'b1;
                        end
                        else
                        begin
                            edge_src[edge_count] = src;
                            edge_dst[edge_count] = dst;
                            edge_count++;
                        end
                    end
                end
            end
            nodes_outstanding = expected_order.size();
        end
    end

endmodule

// File: sim/graph_topological_order_tb.sv
`timescale 1ns / 1ps

module graph_topological_order_tb;

    localparam int MAX_NODES    = 64;
    localparam int MAX_EDGES    = 256;
    localparam int RANDOM_ITEMS = 480;
    localparam int IDLE_PCT     = 22;
    localparam int DRAIN_CYCLES = 64;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic [gto_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [gto_pkg::IN_USER_W-1:0]  s_tuser = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gto_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [gto_pkg::OUT_USER_W-1:0] m_tuser;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [gto_pkg::CNT_W-1:0]      cfg_wr_data = '0;
    logic                           steady = 1'b0;
    int                             mismatch_count;
    int                             nodes_outstanding;

    graph_topological_order #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    graph_topological_order_checker #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .mismatch_count    (mismatch_count),
        .nodes_outstanding (nodes_outstanding)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(12_000_000);
        $display("[graph_topological_order] ERROR");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic int unsigned clamp_count(input int unsigned value);
        if (value == 0)
            return 1;
        if (value > MAX_NODES)
            return MAX_NODES;
        return value;
    endfunction

    // offer one item with random gaps, return at its acceptance edge
    task automatic drive_item(input logic func, input logic [5:0] src, input logic [5:0] dst);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {4'b0000, dst, src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and let every outstanding node arrive
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (nodes_outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_count(input int unsigned value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 7'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int unsigned n;
        int unsigned k;
        int unsigned r;
        int unsigned count_value;
        int unsigned random_items;
        int unsigned phase;
        int unsigned flood_phase;
        int unsigned a;
        int unsigned b;
        logic [5:0]  perm [MAX_NODES];
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [5:0]  swap;
        logic        noisy;

        random_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single node after reset
        drive_item(gto_pkg::FUNC_RUN, 6'd63, 6'd0);
        // edge outside the count, then a self loop
        drive_item(gto_pkg::FUNC_ADD, 6'd63, 6'd63);
        drive_item(gto_pkg::FUNC_ADD, 6'd0, 6'd0);
        drive_item(gto_pkg::FUNC_RUN, 6'd0, 6'd63);
        // zero count acts as one
        write_count(0);
        drive_item(gto_pkg::FUNC_ADD, 6'd1, 6'd0);
        drive_item(gto_pkg::FUNC_RUN, 6'd0, 6'd0);
        // oversized count acts as the maximum, with a duplicate edge
        write_count(127);
        drive_item(gto_pkg::FUNC_ADD, 6'd63, 6'd0);
        drive_item(gto_pkg::FUNC_ADD, 6'd5, 6'd3);
        drive_item(gto_pkg::FUNC_ADD, 6'd5, 6'd3);
        drive_item(gto_pkg::FUNC_ADD, 6'd3, 6'd63);
        drive_item(gto_pkg::FUNC_RUN, 6'd63, 6'd63);
        // full count with a chain
        write_count(MAX_NODES);
        drive_item(gto_pkg::FUNC_ADD, 6'd0, 6'd1);
        drive_item(gto_pkg::FUNC_ADD, 6'd1, 6'd2);
        drive_item(gto_pkg::FUNC_RUN, 6'd0, 6'd0);
        // count lowered before the run hides a cycle
        write_count(10);
        drive_item(gto_pkg::FUNC_ADD, 6'd2, 6'd9);
        drive_item(gto_pkg::FUNC_ADD, 6'd9, 6'd2);
        drive_item(gto_pkg::FUNC_ADD, 6'd1, 6'd3);
        write_count(5);
        drive_item(gto_pkg::FUNC_RUN, 6'd0, 6'd0);
        // just above the maximum, no edges
        write_count(MAX_NODES + 1);
        drive_item(gto_pkg::FUNC_RUN, 6'd21, 6'd42);

        // random graphs, one of them floods the edge store
        flood_phase = $urandom_range(3, 10);
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            // no idling from the flood on for a few graphs
            steady = (phase >= flood_phase && phase < flood_phase + 6);
            if (phase == flood_phase)
            begin
                n = $urandom_range(2, 3);
                write_count(n);
                k = MAX_EDGES + $urandom_range(1, 6);
                for (int e = 0; e < k; e++)
                    drive_item(gto_pkg::FUNC_ADD, 6'($urandom_range(0, n - 1)),
                               6'($urandom_range(0, n - 1)));
                drive_item(gto_pkg::FUNC_RUN, 6'($urandom), 6'($urandom));
                random_items += k + 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    count_value = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127);
                else if (r < 18)
                    count_value = $urandom_range(13, MAX_NODES);
                else
                    count_value = $urandom_range(2, 12);
                write_count(count_value);
                n = clamp_count(count_value);
                noisy = ($urandom_range(0, 99) < 30);
                k = (n < 2) ? 0 : $urandom_range(0, (3 * n < 24) ? 3 * n : 24);
                // random ranking keeps well-formed graphs acyclic
                for (int i = 0; i < n; i++)
                    perm[i] = 6'(i);
                for (int i = n - 1; i > 0; i--)
                begin
                    a = $urandom_range(0, i);
                    swap = perm[i];
                    perm[i] = perm[a];
                    perm[a] = swap;
                end
                for (int e = 0; e < k; e++)
                begin
                    if (!noisy)
                    begin
                        a = $urandom_range(0, n - 2);
                        b = $urandom_range(a + 1, n - 1);
                        src = perm[a];
                        dst = perm[b];
                    end
                    else if ($urandom_range(0, 99) < 60)
                    begin
                        src = 6'($urandom_range(0, n - 1));
                        dst = 6'($urandom_range(0, n - 1));
                    end
                    else
                    begin
                        src = 6'($urandom);
                        dst = 6'($urandom);
                    end
                    drive_item(gto_pkg::FUNC_ADD, src, dst);
                    random_items++;
                end
                // sometimes shrink the graph just before sorting
                if ($urandom_range(0, 99) < 10)
                    write_count($urandom_range(1, n));
                drive_item(gto_pkg::FUNC_RUN, 6'($urandom), 6'($urandom));
                random_items++;
            end
            phase++;
        end

        // drain and verdict
        steady = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[graph_topological_order] OK");
        else
            $display("[graph_topological_order] ERROR");
        $finish;
    end

endmodule
